// ===== design/pcer_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcer_pkg
// Shared types and constants of the per-cell exceedance ranker.
// ----------------------------------------------------------------------------
package pcer_pkg;

	localparam int DATA_W       = 32;
	localparam int DEN_W        = 33;
	localparam int PCT_W        = 15;
	localparam int COUNT_W      = 20;
	localparam int PNUM_W       = 35;
	localparam int CELL_PORT_W  = 10;
	localparam int FULL_PERCENT = 25600;
	localparam int DEF_CELLS    = 1024;
	localparam int DEF_BINS     = 256;

	localparam logic [COUNT_W-1:0] COUNT_MAX   = {COUNT_W{1'b1}};
	localparam logic [DATA_W-1:0]  SAMPLE_MIN  = 32'h8000_0000;
	localparam logic [DATA_W-1:0]  SAMPLE_MAX  = 32'h7FFF_FFFF;
	localparam logic [8:0]         BINS_RESET  = 9'd256;

	typedef enum logic [1:0] {
		OP_SCAN  = 2'd0,
		OP_COUNT = 2'd1,
		OP_RANK  = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	typedef enum logic {
		REG_BINS = 1'b0,
		REG_MISS = 1'b1
	} reg_idx_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_FETCH,
		ST_PREP,
		ST_BSTART,
		ST_BDIV,
		ST_BIN,
		ST_INC,
		ST_RDB,
		ST_PSTART,
		ST_PDIV,
		ST_OUT
	} state_t;

endpackage

// ===== design/per_cell_exceedance_ranker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// per_cell_exceedance_ranker
// Per-cell range scan, cumulative histogram and exceedance percent ranking.
// ----------------------------------------------------------------------------
// Items enter on the s_ stream: tuser carries the pass (0 range scan,
// 1 histogram count, 2 rank), tdata the cell and the sample. Only rank items
// give a result, on the m_ stream: tdata holds the cell and the percent in
// Q.8, tuser the missing flag. Bin count and missing code are set over APB;
// they are to be written while the block is idle, which the block does not enforce.
// One item is worked on at a time. A count finds the sample's bin, in the
// bit-serial divider unless the sample is at or above the range top, then
// runs a read-modify-write loop over the count memory that adds one to each
// bin from 0 to the sample's bin. A rank makes up to two passes through the
// shared bit-serial divider, one for the bin and one for the percent.
// After reset the block sweeps the count memory and the range memory to
// their start values and accepts no item until the sweep ends. A result
// waits in the output register while the receiver stalls; the next item
// is still accepted and holds only when it has a result of its own to
// deliver.
// ----------------------------------------------------------------------------
module per_cell_exceedance_ranker
	import pcer_pkg::*;
#(
	parameter int NUM_CELLS = DEF_CELLS,
	parameter int NUM_BINS  = DEF_BINS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // cell_req[9:0], sample[41:10], zero pad
	input  logic [1:0]  s_tuser,   // op[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // out_cell[9:0], percent[24:10], zero pad
	output logic        m_tuser,   // is_missing
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int TOTAL = NUM_CELLS * NUM_BINS;
	localparam int AW    = (TOTAL > 1) ? $clog2(TOTAL) : 1;
	localparam int CW    = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1;
	localparam int BW    = $clog2(NUM_BINS);
	localparam int QW    = (BW > PCT_W) ? BW : PCT_W;
	localparam int NW    = (DEN_W + BW > PNUM_W) ? DEN_W + BW : PNUM_W;

	state_t st_q, st_d;

	logic [8:0]        bins_q;
	logic [31:0]       miss_val_q;
	logic              cfg_wr;

	logic [1:0]        op_q;
	logic [CW-1:0]     cidx_q;
	logic              vcell_q;
	logic              miss_q;
	logic signed [31:0] samp_q;
	logic [AW-1:0]     base_q;
	logic [DEN_W-1:0]  d_q;
	logic [DEN_W-1:0]  den_q;
	logic [COUNT_W-1:0] tot_q;
	logic [NW-1:0]     num_q;
	logic [BW-1:0]     bin_q;
	logic [BW-1:0]     k_q;
	logic [PCT_W-1:0]  pct_q;
	logic [AW-1:0]     clr_q;

	logic              m_valid_q;
	logic [9:0]        m_cell_q;
	logic [PCT_W-1:0]  m_pct_q;
	logic              m_miss_q;

	logic [CELL_PORT_W-1:0] in_cell;
	logic [31:0]       in_samp;
	logic [31:0]       in_cell_ext;
	logic              in_vcell;
	logic              in_miss;
	logic [CW-1:0]     in_cidx;
	logic [AW-1:0]     in_base;
	logic              accept;

	logic [31:0]       bact32;
	logic [BW-1:0]     bm1;

	logic              mm_we;
	logic [CW-1:0]     mm_waddr;
	logic [63:0]       mm_wdata;
	logic [CW-1:0]     mm_raddr;
	logic [63:0]       mm_rdata;
	logic              cn_we;
	logic [AW-1:0]     cn_waddr;
	logic [COUNT_W-1:0] cn_wdata;
	logic [AW-1:0]     cn_raddr;
	logic [COUNT_W-1:0] cn_rdata;

	logic signed [31:0] rd_mx;
	logic signed [31:0] rd_mn;
	logic [COUNT_W-1:0] rd_tot;
	logic              flat;
	logic              below;

	logic              div_start;
	logic [NW-1:0]     div_num;
	logic [DEN_W-1:0]  div_den;
	logic              div_done;
	logic [QW-1:0]     div_quo;

	logic              out_free;
	logic              out_load;

	assign in_cell     = s_tdata[9:0];
	assign in_samp     = s_tdata[41:10];
	assign in_cell_ext = 32'(in_cell);
	assign in_vcell    = in_cell_ext < 32'(NUM_CELLS);
	assign in_miss     = in_samp == miss_val_q;
	assign in_cidx     = in_cell_ext[CW-1:0];
	assign in_base     = AW'(in_cidx) * AW'(NUM_BINS);
	assign accept      = s_tvalid && s_tready;

	assign bact32 = (bins_q == 9'd0) ? 32'd1 :
	                (32'(bins_q) > 32'(NUM_BINS)) ? 32'(NUM_BINS) : 32'(bins_q);
	assign bm1    = BW'(bact32 - 32'd1);

	assign rd_mx  = mm_rdata[63:32];
	assign rd_mn  = mm_rdata[31:0];
	assign rd_tot = vcell_q ? cn_rdata : '0;
	assign flat   = rd_mx <= rd_mn;
	assign below  = samp_q < rd_mn;

	assign out_free = !m_valid_q || m_tready;
	assign s_tready = st_q == ST_IDLE;

	// Configuration port.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bins_q     <= BINS_RESET;
			miss_val_q <= SAMPLE_MIN;
		end else if (cfg_wr) begin
			case (reg_idx_t'(paddr[2]))
				REG_BINS: bins_q     <= pwdata[8:0];
				REG_MISS: miss_val_q <= pwdata;
				default:  bins_q     <= bins_q;
			endcase
		end
	end

	always_comb begin
		case (reg_idx_t'(paddr[2]))
			REG_BINS: prdata = 32'(bins_q);
			REG_MISS: prdata = miss_val_q;
			default:  prdata = '0;
		endcase
	end

	pcer_ram #(.WIDTH(64), .DEPTH(NUM_CELLS), .AW(CW)) u_range_ram (
		.clk   (clk),
		.we    (mm_we),
		.waddr (mm_waddr),
		.wdata (mm_wdata),
		.raddr (mm_raddr),
		.rdata (mm_rdata)
	);

	pcer_ram #(.WIDTH(COUNT_W), .DEPTH(TOTAL), .AW(AW)) u_count_ram (
		.clk   (clk),
		.we    (cn_we),
		.waddr (cn_waddr),
		.wdata (cn_wdata),
		.raddr (cn_raddr),
		.rdata (cn_rdata)
	);

	pcer_div #(.NW(NW), .DW(DEN_W), .QW(QW)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quo    (div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_CLEAR;
		end else begin
			st_q <= st_d;
		end
	end

	always_comb begin
		st_d      = st_q;
		mm_we     = 1'b0;
		mm_waddr  = cidx_q;
		mm_wdata  = {(samp_q > rd_mx) ? samp_q : rd_mx, below ? samp_q : rd_mn};
		mm_raddr  = in_cidx;
		cn_we     = 1'b0;
		cn_waddr  = base_q + AW'(k_q);
		cn_wdata  = (cn_rdata == COUNT_MAX) ? cn_rdata : cn_rdata + 1'b1;
		cn_raddr  = in_base;
		div_start = 1'b0;
		div_num   = num_q;
		div_den   = den_q;
		out_load  = 1'b0;
		case (st_q)
			ST_CLEAR: begin
				cn_we    = 1'b1;
				cn_waddr = clr_q;
				cn_wdata = '0;
				mm_we    = 32'(clr_q) < 32'(NUM_CELLS);
				mm_waddr = clr_q[CW-1:0];
				mm_wdata = {SAMPLE_MIN, SAMPLE_MAX};
				if (clr_q == AW'(TOTAL - 1)) begin
					st_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (accept) begin
					case (op_t'(s_tuser))
						OP_SCAN, OP_COUNT: begin
							if (in_vcell && !in_miss) begin
								st_d = ST_FETCH;
							end
						end
						OP_RANK: st_d = ST_FETCH;
						default: st_d = ST_IDLE;
					endcase
				end
			end
			ST_FETCH: begin
				case (op_t'(op_q))
					OP_SCAN: begin
						mm_we = 1'b1;
						st_d  = ST_IDLE;
					end
					OP_COUNT: st_d = (flat || below) ? ST_IDLE : ST_PREP;
					default: begin
						if (miss_q || rd_tot == '0 || flat || below) begin
							st_d = ST_OUT;
						end else begin
							st_d = ST_PREP;
						end
					end
				endcase
			end
			ST_PREP: st_d = (d_q >= den_q) ? ST_BIN : ST_BSTART;
			ST_BSTART: begin
				div_start = 1'b1;
				st_d      = ST_BDIV;
			end
			ST_BDIV: begin
				if (div_done) begin
					st_d = ST_BIN;
				end
			end
			ST_BIN: begin
				if (op_t'(op_q) == OP_COUNT) begin
					cn_raddr = base_q;
					st_d     = ST_INC;
				end else begin
					cn_raddr = base_q + AW'(bin_q);
					st_d     = ST_RDB;
				end
			end
			ST_INC: begin
				cn_we    = 1'b1;
				cn_raddr = base_q + AW'(k_q) + AW'(1);
				if (k_q == bin_q) begin
					st_d = ST_IDLE;
				end
			end
			ST_RDB: st_d = ST_PSTART;
			ST_PSTART: begin
				div_start = 1'b1;
				div_den   = DEN_W'(tot_q);
				st_d      = ST_PDIV;
			end
			ST_PDIV: begin
				if (div_done) begin
					st_d = ST_OUT;
				end
			end
			ST_OUT: begin
				if (out_free) begin
					out_load = 1'b1;
					st_d     = ST_IDLE;
				end
			end
			default: st_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (st_q == ST_CLEAR) begin
			clr_q <= clr_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q    <= s_tuser;
			cidx_q  <= in_cidx;
			vcell_q <= in_vcell;
			miss_q  <= in_miss;
			samp_q  <= in_samp;
			base_q  <= in_base;
		end
		if (st_q == ST_FETCH) begin
			d_q   <= {samp_q[31], samp_q} - {rd_mn[31], rd_mn};
			den_q <= {rd_mx[31], rd_mx} - {rd_mn[31], rd_mn};
			tot_q <= rd_tot;
			pct_q <= miss_q ? '0 : PCT_W'(FULL_PERCENT);
		end
		if (st_q == ST_PREP) begin
			bin_q <= bm1;
			num_q <= NW'(d_q) * NW'(bm1);
		end
		if (st_q == ST_BDIV && div_done) begin
			bin_q <= div_quo[BW-1:0];
		end
		if (st_q == ST_BIN) begin
			k_q <= '0;
		end else if (st_q == ST_INC) begin
			k_q <= k_q + 1'b1;
		end
		if (st_q == ST_RDB) begin
			num_q <= NW'(cn_rdata) * NW'(FULL_PERCENT);
		end
		if (st_q == ST_PDIV && div_done) begin
			pct_q <= div_quo[PCT_W-1:0];
		end
		if (out_load) begin
			m_cell_q <= CELL_PORT_W'(cidx_q);
			m_pct_q  <= pct_q;
			m_miss_q <= miss_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (out_load) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {7'd0, m_pct_q, m_cell_q};
	assign m_tuser  = m_miss_q;

	a_inc_bound: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == ST_INC |-> k_q <= bin_q)
		else $error("count loop ran past the sample's bin");

	a_div_owner: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (st_q == ST_BDIV || st_q == ST_PDIV))
		else $error("divider finished outside a division state");

	a_pct_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_valid_q |-> (m_pct_q <= PCT_W'(FULL_PERCENT) && (!m_miss_q || m_pct_q == '0)))
		else $error("result percent out of range");

	a_no_accept_clear: assert property (@(posedge clk) disable iff (!arst_n)
		$past(st_q) == ST_CLEAR && st_q == ST_IDLE |-> $past(clr_q) == AW'(TOTAL - 1))
		else $error("clearing sweep ended early");

endmodule

// ===== design/pcer_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcer_ram
// Simple dual-port RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module pcer_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== design/pcer_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcer_div
// Restoring divider, one quotient bit per cycle. The numerator bits above
// the quotient width must be below the denominator.
// ----------------------------------------------------------------------------
module pcer_div
	import pcer_pkg::*;
#(
	parameter int NW = 41,
	parameter int DW = 33,
	parameter int QW = 15
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic          done,
	output logic [QW-1:0] quo
);

	localparam int CW = $clog2(QW + 1);

	logic          busy_q;
	logic [CW-1:0] cnt_q;
	logic [DW-1:0] rem_q;
	logic [DW-1:0] den_q;
	logic [QW-1:0] lo_q;
	logic [QW-1:0] quo_q;
	logic [DW:0]   trial;
	logic          fits;

	assign trial = {rem_q, lo_q[QW-1]};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CW'(QW);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CW'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= DW'(num[NW-1:QW]);
			lo_q  <= num[QW-1:0];
			den_q <= den;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= fits ? DW'(trial - {1'b0, den_q}) : trial[DW-1:0];
			lo_q  <= {lo_q[QW-2:0], 1'b0};
			quo_q <= {quo_q[QW-2:0], fits};
		end
	end

	assign done = busy_q && (cnt_q == CW'(1));
	assign quo  = {quo_q[QW-2:0], fits};

endmodule
